// ----- hw/rtl/pss_pkg.sv -----
// Shared types and codes for the periodic stream scheduler.
// No dependencies.
`default_nettype none
package pss_pkg;
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_END = 3'd1, CMD_GET = 3'd2, CMD_LIST = 3'd3,
    CMD_TICK = 3'd4, CMD_POLL = 3'd5, CMD_KILL = 3'd6, CMD_STOP = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_UNKNOWN = 4'd1, ST_NOSTREAM = 4'd2, ST_ID_ZERO = 4'd3,
    ST_ID_INVALID = 4'd4, ST_IN_USE = 4'd5, ST_FULL = 4'd6, ST_NO_SLOT = 4'd7,
    ST_NOT_FOUND = 4'd8, ST_MISMATCH = 4'd9, ST_NONE = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    CFG_MASK = 2'd0, CFG_COUNT = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FSM_IDLE, FSM_SCAN, FSM_FINISH, FSM_OUT
  } fsm_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  sid;
    logic [15:0] rate;
    logic [4:0]  cmd_sel;
    logic        has_args;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  out_sid;
    logic [4:0]  out_cmd_sel;
    logic [15:0] out_rate;
    logic        out_has_args;
    logic [15:0] active_mask;
    logic        fired;
  } out_word_t;
endpackage
`default_nettype wire

// ----- hw/rtl/pss_if.sv -----
// Valid/ready channel carrying one word of type T.
// No dependencies; the payload type is the parameter T.
`default_nettype none
interface pss_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pss_ctrl.sv -----
// Sequencer for the scheduler: accept, scan the table, present the result.
// Depends on pss_pkg.
`default_nettype none
module pss_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic            out_fire,
  input  pss_pkg::dp_stat_t    stat,
  output pss_pkg::dp_cmd_t     cmd,
  output logic                 in_ready,
  output logic                 out_valid
);
  pss_pkg::fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pss_pkg::FSM_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pss_pkg::FSM_IDLE:   if (in_fire) state_nxt = pss_pkg::FSM_SCAN;
      pss_pkg::FSM_SCAN:   if (stat.last) state_nxt = pss_pkg::FSM_FINISH;
      pss_pkg::FSM_FINISH: state_nxt = pss_pkg::FSM_OUT;
      pss_pkg::FSM_OUT:    if (out_fire) state_nxt = pss_pkg::FSM_IDLE;
      default:             state_nxt = pss_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == pss_pkg::FSM_IDLE);
    out_valid  = (state_r == pss_pkg::FSM_OUT);
    cmd.clear  = in_fire;
    cmd.step   = (state_r == pss_pkg::FSM_SCAN);
    cmd.finish = (state_r == pss_pkg::FSM_FINISH);
  end

  a_out_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid) else $error("result not shown after finish");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_ready) else $error("accepting while scanning");
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && stat.last) |=> cmd.finish) else $error("scan end lost");
endmodule
`default_nettype wire

// ----- hw/rtl/pss_dp.sv -----
// Table datapath: one entry visited per cycle, then a commit step.
// Depends on pss_pkg.
`default_nettype none
module pss_dp #(
  parameter int TABLE_ENTRIES = 12,
  parameter int ARG_SLOTS     = 8,
  parameter int MAX_ID        = 15
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  pss_pkg::dp_cmd_t     cmd,
  output pss_pkg::dp_stat_t    stat,
  input  pss_pkg::in_word_t    in_word,
  input  wire logic [31:0]     mask,
  input  wire logic [5:0]      count,
  output pss_pkg::out_word_t   res
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  logic [3:0]  id_r   [TABLE_ENTRIES];
  logic [4:0]  com_r  [TABLE_ENTRIES];
  logic [15:0] per_r  [TABLE_ENTRIES];
  logic [15:0] cd_r   [TABLE_ENTRIES];
  logic [7:0]  pend_r [TABLE_ENTRIES];
  logic        held_r [TABLE_ENTRIES];
  logic [4:0]  slots_r;

  pss_pkg::in_word_t req_r;
  logic [IW-1:0] idx_r;
  logic          hit_r, free_ok_r, pfound_r;
  logic [IW-1:0] hit_idx_r, free_idx_r, pidx_r;
  logic [15:0]   cd_copy_r, amask_r;
  pss_pkg::out_word_t res_r;

  logic [15:0] rate_eff;
  logic [3:0]  cur_id;
  logic        cur_act;

  pss_pkg::status_t st;
  logic known, rel;

  assign rate_eff = (req_r.rate == 16'd0) ? 16'd1 : req_r.rate;
  assign cur_id   = id_r[idx_r];
  assign cur_act  = (cur_id != 4'd0);
  assign stat.last = (idx_r == LAST);
  assign res = res_r;

  // Scan registers
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      req_r     <= in_word;
      idx_r     <= '0;
      hit_r     <= 1'b0;
      free_ok_r <= 1'b0;
      pfound_r  <= 1'b0;
      amask_r   <= '0;
      cd_copy_r <= (in_word.rate == 16'd0) ? 16'd1 : in_word.rate;
      hit_idx_r <= '0;
      free_idx_r <= '0;
      pidx_r    <= '0;
    end else if (cmd.step) begin
      if (!stat.last) idx_r <= idx_r + IW'(1);
      if (cur_act) begin
        amask_r[cur_id] <= 1'b1;
        if ({4'd0, cur_id} == req_r.sid && !hit_r) begin
          hit_r <= 1'b1;
          hit_idx_r <= idx_r;
        end
        if (per_r[idx_r] == rate_eff) cd_copy_r <= cd_r[idx_r];
        if (pend_r[idx_r] != 8'd0 && !pfound_r) begin
          pfound_r <= 1'b1;
          pidx_r <= idx_r;
        end
      end else if (!free_ok_r) begin
        free_ok_r <= 1'b1;
        free_idx_r <= idx_r;
      end
    end
  end

  // Tick updates each active entry as it is visited; the finish step commits poll and add
  always_ff @(posedge clk) begin
    if (cmd.step && req_r.cmd == pss_pkg::CMD_TICK && cur_act) begin
      if (cd_r[idx_r] == 16'd1) begin
        cd_r[idx_r]   <= per_r[idx_r];
        pend_r[idx_r] <= pend_r[idx_r] + 8'd1;
      end else begin
        cd_r[idx_r] <= cd_r[idx_r] - 16'd1;
      end
    end else if (cmd.finish) begin
      if (req_r.cmd == pss_pkg::CMD_POLL && pfound_r)
        pend_r[pidx_r] <= pend_r[pidx_r] - 8'd1;
      else if (req_r.cmd == pss_pkg::CMD_ADD && st == pss_pkg::ST_OK) begin
        com_r[free_idx_r]  <= req_r.cmd_sel;
        per_r[free_idx_r]  <= rate_eff;
        cd_r[free_idx_r]   <= cd_copy_r;
        pend_r[free_idx_r] <= 8'd0;
      end
    end
  end

  // Status, decided combinationally from scan results
  always_comb begin
    known = ({1'b0, req_r.cmd_sel} < count);
    st = pss_pkg::ST_OK;
    rel = 1'b0;
    unique case (pss_pkg::cmd_t'(req_r.cmd))
      pss_pkg::CMD_ADD: begin
        if (!known) st = pss_pkg::ST_UNKNOWN;
        else if (!mask[req_r.cmd_sel]) st = pss_pkg::ST_NOSTREAM;
        else if (req_r.sid == 8'd0) st = pss_pkg::ST_ID_ZERO;
        else if (req_r.sid > 8'(MAX_ID)) st = pss_pkg::ST_ID_INVALID;
        else if (hit_r) st = pss_pkg::ST_IN_USE;
        else if (!free_ok_r) st = pss_pkg::ST_FULL;
        else if (req_r.has_args && slots_r >= 5'(ARG_SLOTS)) st = pss_pkg::ST_NO_SLOT;
      end
      pss_pkg::CMD_END, pss_pkg::CMD_KILL, pss_pkg::CMD_GET: begin
        if (req_r.sid == 8'd0) st = pss_pkg::ST_ID_ZERO;
        else if (!hit_r) st = pss_pkg::ST_NOT_FOUND;
        else if (req_r.cmd == pss_pkg::CMD_END && com_r[hit_idx_r] != req_r.cmd_sel)
          st = pss_pkg::ST_MISMATCH;
        else rel = (req_r.cmd != pss_pkg::CMD_GET);
      end
      pss_pkg::CMD_POLL: if (!pfound_r) st = pss_pkg::ST_NONE;
      default: st = pss_pkg::ST_OK;
    endcase
  end

  // Commit: ids, slot marks and the slot count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        id_r[i] <= 4'd0;
        held_r[i] <= 1'b0;
      end
      slots_r <= '0;
    end else if (cmd.finish) begin
      if (req_r.cmd == pss_pkg::CMD_STOP) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          id_r[i] <= 4'd0;
          held_r[i] <= 1'b0;
        end
        slots_r <= '0;
      end else if (req_r.cmd == pss_pkg::CMD_ADD && st == pss_pkg::ST_OK) begin
        id_r[free_idx_r]   <= req_r.sid[3:0];
        held_r[free_idx_r] <= req_r.has_args;
        if (req_r.has_args) slots_r <= slots_r + 5'd1;
      end else if (rel) begin
        id_r[hit_idx_r] <= 4'd0;
        if (held_r[hit_idx_r]) begin
          held_r[hit_idx_r] <= 1'b0;
          if (slots_r != 5'd0) slots_r <= slots_r - 5'd1;
        end
      end
    end
  end

  // Result word is cleared on the last scan step and captured on the finish step
  logic [IW-1:0] rep;
  logic          show;
  always_comb begin
    rep  = (req_r.cmd == pss_pkg::CMD_POLL) ? pidx_r : hit_idx_r;
    show = (st == pss_pkg::ST_OK) &&
           (req_r.cmd == pss_pkg::CMD_GET || req_r.cmd == pss_pkg::CMD_POLL);
  end

  always_ff @(posedge clk) begin
    if (cmd.step && stat.last) begin
      res_r <= '0;
    end else if (cmd.finish) begin
      res_r.status       <= st;
      res_r.out_sid      <= show ? id_r[rep] : 4'd0;
      res_r.out_cmd_sel  <= show ? com_r[rep] : 5'd0;
      res_r.out_rate     <= show ? per_r[rep] : 16'd0;
      res_r.out_has_args <= show ? held_r[rep] : 1'b0;
      res_r.active_mask  <= (req_r.cmd == pss_pkg::CMD_LIST) ? amask_r : 16'd0;
      res_r.fired        <= (req_r.cmd == pss_pkg::CMD_POLL) && pfound_r;
    end
  end

  a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slots_r <= 5'(ARG_SLOTS) || ARG_SLOTS == 0) else $error("slot count overrun");
  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && req_r.cmd == pss_pkg::CMD_POLL && pfound_r) |=> res_r.fired)
    else $error("poll hit not reported");
  a_idx_reset: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> idx_r == '0) else $error("scan index not cleared");
endmodule
`default_nettype wire

// ----- hw/rtl/periodic_stream_scheduler.sv -----
// Periodic stream scheduler top level: config registers, channels, controller, datapath.
// Depends on pss_pkg, pss_if, pss_ctrl and pss_dp.
// Each word is accepted, scanned against each table entry in turn, then committed in a finish
// step; the result is then held until it is accepted.
// Next word is taken the cycle after the result is accepted, never while one is in flight.
// Synchronous active-low reset clears all entries and slot marks and restores config defaults.
`default_nettype none
module periodic_stream_scheduler #(
  parameter int TABLE_ENTRIES = 12,
  parameter int ARG_SLOTS     = 8,
  parameter int MAX_ID        = 15
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pss_if.sink              in_ch,
  pss_if.source            out_ch,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  logic [31:0] mask_r;
  logic [5:0]  count_r;
  pss_pkg::dp_cmd_t  dcmd;
  pss_pkg::dp_stat_t dstat;
  logic in_ready, out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= 32'h1F08;
      count_r <= 6'd18;
    end else if (cfg_we) begin
      if (cfg_index == 1'(pss_pkg::CFG_MASK)) mask_r <= cfg_wdata;
      else count_r <= cfg_wdata[5:0];
    end
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  pss_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in_ch.valid && in_ready),
    .out_fire(out_valid && out_ch.ready),
    .stat(dstat), .cmd(dcmd), .in_ready, .out_valid
  );

  pss_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .ARG_SLOTS(ARG_SLOTS), .MAX_ID(MAX_ID)) u_dp (
    .clk, .rst_n, .cmd(dcmd), .stat(dstat), .in_word(in_ch.data),
    .mask(mask_r), .count(count_r), .res(out_ch.data)
  );
endmodule
`default_nettype wire
